FILE: hdl/rhc_pkg.sv
package rhc_pkg;

	// channel byte width and the width of the hue numerator/divisor (6 * 255 fits in 11 bits)
	localparam int CH_W  = 8;
	localparam int ADJ_W = 11;

	typedef logic [CH_W-1:0]  chan_t;
	typedef logic [ADJ_W-1:0] adj_t;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// state carried down the divider pipeline next to the quotient bits
	typedef struct packed {
		logic  grey;
		logic  black;
		adj_t  hue_rem;
		adj_t  hue_div;
		chan_t sat_rem;
		chan_t sat_div;
		chan_t value;
	} div_ctl_t;

endpackage

FILE: hdl/rhc_pix_if.sv
interface rhc_pix_if;
	import rhc_pkg::*;

	logic  valid;
	logic  ready;
	chan_t red;
	chan_t green;
	chan_t blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);

endinterface

FILE: hdl/rhc_hsv_if.sv
interface rhc_hsv_if #(
	parameter int FRACTION_BITS = 16
);
	import rhc_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [FRACTION_BITS-1:0] hue;
	logic [FRACTION_BITS:0]   saturation;
	chan_t                  value;

	modport source (output valid, hue, saturation, value, input ready);
	modport sink (input valid, hue, saturation, value, output ready);

endinterface

FILE: hdl/rhc_prep.sv
module rhc_prep import rhc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_valid,
	input  chan_t    red,
	input  chan_t    green,
	input  chan_t    blue,
	output logic     out_valid,
	output div_ctl_t ctl,
	output logic     sat_int
);

	logic    valid_s1;
	chan_t   r_s1, g_s1, b_s1, mx_s1, mn_s1;
	sector_t sec_s1;

	chan_t   mx, mn;
	sector_t sec;

	// max with ties going to the earlier channel in red, green, blue order
	always_comb begin
		mx  = red;
		sec = SEC_RED;
		if (green > mx) begin
			mx  = green;
			sec = SEC_GREEN;
		end
		if (blue > mx) begin
			mx  = blue;
			sec = SEC_BLUE;
		end
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1   <= red;
			g_s1   <= green;
			b_s1   <= blue;
			mx_s1  <= mx;
			mn_s1  <= mn;
			sec_s1 <= sec;
		end
	end

	chan_t delta;
	adj_t  d2, d4, d6, adj;

	always_comb begin
		delta = mx_s1 - mn_s1;
		d2    = {2'b00, delta, 1'b0};
		d4    = {1'b0, delta, 2'b00};
		d6    = d2 + d4;
		unique case (sec_s1)
			SEC_RED: begin
				if (g_s1 >= b_s1) adj = ADJ_W'(g_s1) - ADJ_W'(b_s1);
				else adj = d6 - (ADJ_W'(b_s1) - ADJ_W'(g_s1));
			end
			SEC_GREEN: adj = d2 + ADJ_W'(b_s1) - ADJ_W'(r_s1);
			SEC_BLUE:  adj = d4 + ADJ_W'(r_s1) - ADJ_W'(g_s1);
			default:   adj = '0;
		endcase
	end

	logic     valid_s2;
	div_ctl_t ctl_s2;
	logic     sat_int_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	// delta never exceeds max, so the integer bit of saturation is set only when they match
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2.grey    <= (delta == '0);
			ctl_s2.black   <= (mx_s1 == '0);
			ctl_s2.hue_rem <= adj;
			ctl_s2.hue_div <= d6;
			ctl_s2.sat_rem <= (delta == mx_s1) ? '0 : delta;
			ctl_s2.sat_div <= mx_s1;
			ctl_s2.value   <= mx_s1;
			sat_int_s2     <= (delta == mx_s1);
		end
	end

	assign out_valid = valid_s2;
	assign ctl       = ctl_s2;
	assign sat_int   = sat_int_s2;

endmodule

FILE: hdl/rhc_div_stage.sv
module rhc_div_stage import rhc_pkg::*; #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  div_ctl_t                 ctl_in,
	input  logic [FRACTION_BITS-1:0] hue_q_in,
	input  logic [FRACTION_BITS:0]   sat_q_in,
	output logic                     out_valid,
	output div_ctl_t                 ctl_out,
	output logic [FRACTION_BITS-1:0] hue_q_out,
	output logic [FRACTION_BITS:0]   sat_q_out
);

	logic [ADJ_W:0] hue_sh, hue_dv, hue_nx;
	logic [CH_W:0]  sat_sh, sat_dv, sat_nx;
	logic           hue_bit, sat_bit;
	div_ctl_t       ctl_nx;

	// one restoring shift-subtract step for each divider
	always_comb begin
		hue_sh  = {ctl_in.hue_rem, 1'b0};
		hue_dv  = {1'b0, ctl_in.hue_div};
		hue_bit = (hue_sh >= hue_dv);
		hue_nx  = hue_bit ? (hue_sh - hue_dv) : hue_sh;
		sat_sh  = {ctl_in.sat_rem, 1'b0};
		sat_dv  = {1'b0, ctl_in.sat_div};
		sat_bit = (sat_sh >= sat_dv);
		sat_nx  = sat_bit ? (sat_sh - sat_dv) : sat_sh;
		ctl_nx         = ctl_in;
		ctl_nx.hue_rem = hue_nx[ADJ_W-1:0];
		ctl_nx.sat_rem = sat_nx[CH_W-1:0];
	end

	logic                     valid_s1;
	div_ctl_t                 ctl_s1;
	logic [FRACTION_BITS-1:0] hue_q_s1;
	logic [FRACTION_BITS:0]   sat_q_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1   <= ctl_nx;
			hue_q_s1 <= {hue_q_in[FRACTION_BITS-2:0], hue_bit};
			sat_q_s1 <= {sat_q_in[FRACTION_BITS-1:0], sat_bit};
		end
	end

	assign out_valid = valid_s1;
	assign ctl_out   = ctl_s1;
	assign hue_q_out = hue_q_s1;
	assign sat_q_out = sat_q_s1;

endmodule

FILE: hdl/rgb_to_hsv_converter_top.sv
// Channel | Dir | Payload                                        | Handshake
// pixel   | in  | red[7:0], green[7:0], blue[7:0]                | valid/ready
// hsv     | out | hue[F-1:0], saturation[F:0], value[7:0]        | valid/ready
//
// One pixel per cycle sustained while hsv does not stall; a result passes through the
// two-stage front end and then the hue and saturation shift-subtract dividers, which
// produce one quotient bit per stage.
// Reset clears only valid bits; no state is kept between pixels.
// A skid register at the output holds one beat when hsv stalls; while it is full
// the whole pipeline holds and pixel.ready is low.
module rgb_to_hsv_converter_top import rhc_pkg::*; #(
	parameter int FRACTION_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	rhc_pix_if.sink   pixel,
	rhc_hsv_if.source hsv
);

	localparam logic [FRACTION_BITS:0] SAT_FULL = (FRACTION_BITS+1)'(1) << FRACTION_BITS;

	logic                     en;
	logic                     v_p   [0:FRACTION_BITS];
	div_ctl_t                 ctl_p [0:FRACTION_BITS];
	logic [FRACTION_BITS-1:0] hue_p [0:FRACTION_BITS];
	logic [FRACTION_BITS:0]   sat_p [0:FRACTION_BITS];
	logic                     sat_int;

	logic                     skid_v_q;
	logic [FRACTION_BITS-1:0] skid_hue_q;
	logic [FRACTION_BITS:0]   skid_sat_q;
	chan_t                    skid_val_q;

	assign en          = !skid_v_q;
	assign pixel.ready = en;

	rhc_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pixel.valid),
		.red       (pixel.red),
		.green     (pixel.green),
		.blue      (pixel.blue),
		.out_valid (v_p[0]),
		.ctl       (ctl_p[0]),
		.sat_int   (sat_int)
	);

	assign hue_p[0] = '0;
	assign sat_p[0] = {{FRACTION_BITS{1'b0}}, sat_int};

	for (genvar i = 0; i < FRACTION_BITS; i++) begin : g_div
		rhc_div_stage #(
			.FRACTION_BITS (FRACTION_BITS)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (v_p[i]),
			.ctl_in    (ctl_p[i]),
			.hue_q_in  (hue_p[i]),
			.sat_q_in  (sat_p[i]),
			.out_valid (v_p[i+1]),
			.ctl_out   (ctl_p[i+1]),
			.hue_q_out (hue_p[i+1]),
			.sat_q_out (sat_p[i+1])
		);
	end

	logic                     v_last;
	logic [FRACTION_BITS-1:0] hue_fin;
	logic [FRACTION_BITS:0]   sat_fin;

	// grey pixels have no hue, black pixels no saturation
	assign v_last  = v_p[FRACTION_BITS];
	assign hue_fin = ctl_p[FRACTION_BITS].grey ? '0 : hue_p[FRACTION_BITS];
	assign sat_fin = ctl_p[FRACTION_BITS].black ? '0 : sat_p[FRACTION_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (hsv.ready) skid_v_q <= 1'b0;
		end else if (v_last && !hsv.ready) begin
			skid_v_q <= 1'b1;
		end
	end

	// park the last stage's beat while the pipeline advances under it
	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			skid_hue_q <= hue_fin;
			skid_sat_q <= sat_fin;
			skid_val_q <= ctl_p[FRACTION_BITS].value;
		end
	end

	assign hsv.valid      = skid_v_q | v_last;
	assign hsv.hue        = skid_v_q ? skid_hue_q : hue_fin;
	assign hsv.saturation = skid_v_q ? skid_sat_q : sat_fin;
	assign hsv.value      = skid_v_q ? skid_val_q : ctl_p[FRACTION_BITS].value;

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv.valid |-> (hsv.saturation <= SAT_FULL))
		else $error("saturation above full scale");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(v_last && !hsv.ready))
		else $error("skid filled without a stalled beat");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |=> $stable(v_last))
		else $error("pipeline moved while skid full");

endmodule
